>>> rtl/pca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants for the pixel color adjust block.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int CH_W = 8;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;
    localparam logic [CH_W-1:0] CH_MID = 8'd127;

    typedef enum logic [2:0] {
        MODE_NEGATIVE    = 3'd0,
        MODE_GRAYSCALE   = 3'd1,
        MODE_BLUE_TINT   = 3'd2,
        MODE_GREEN_TINT  = 3'd3,
        MODE_RED_TINT    = 3'd4,
        MODE_CONTRAST_UP = 3'd5,
        MODE_CONTRAST_DN = 3'd6
    } op_mode_t;

    // red in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

endpackage
`default_nettype wire

>>> rtl/pca_pixel_op.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_pixel_op
// Combinational point operation on one RGB pixel, selected by the mode.
// ----------------------------------------------------------------------------
module pca_pixel_op (
    input  wire pca_pkg::op_mode_t mode,
    input  wire pca_pkg::pixel_t   pix,
    output pca_pkg::pixel_t        result
);

    // floor(x/3) = (x*683) >> 11 for x < 2048
    localparam logic [9:0] DIV3_MUL = 10'd683;
    localparam int         DIV3_SHR = 11;

    logic [9:0]  sum;
    logic [19:0] prod;
    logic [7:0]  mean;
    logic        bright;

    function automatic logic [7:0] tint(input logic [7:0] c);
        logic [8:0] s;
        s = {1'b0, c} + {2'b00, c[7:1]};
        return s[8] ? pca_pkg::CH_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] contrast(input logic [7:0] c,
                                            input logic       raise,
                                            input logic       upper);
        logic [8:0] v;
        logic [7:0] r;
        v = raise ? ({1'b0, c} + {3'b000, c[7:2]}) : ({1'b0, c} - {3'b000, c[7:2]});
        if (upper)
        begin
            if (v < {1'b0, pca_pkg::CH_MID})
                r = pca_pkg::CH_MID;
            else if (v[8])
                r = pca_pkg::CH_MAX;
            else
                r = v[7:0];
        end
        else
        begin
            if (v > {1'b0, pca_pkg::CH_MID})
                r = pca_pkg::CH_MID;
            else
                r = v[7:0];
        end
        return r;
    endfunction

    assign sum    = {2'b00, pix.red} + {2'b00, pix.green} + {2'b00, pix.blue};
    assign prod   = {10'd0, sum} * {10'd0, DIV3_MUL};
    assign mean   = prod[DIV3_SHR +: 8];
    assign bright = mean > pca_pkg::CH_MID;

    always_comb
    begin
        result = pix;
        unique case (mode)
            pca_pkg::MODE_NEGATIVE:
            begin
                result.red   = pca_pkg::CH_MAX - pix.red;
                result.green = pca_pkg::CH_MAX - pix.green;
                result.blue  = pca_pkg::CH_MAX - pix.blue;
            end
            pca_pkg::MODE_GRAYSCALE:
            begin
                result.red   = mean;
                result.green = mean;
                result.blue  = mean;
            end
            pca_pkg::MODE_BLUE_TINT:  result.blue  = tint(pix.blue);
            pca_pkg::MODE_GREEN_TINT: result.green = tint(pix.green);
            pca_pkg::MODE_RED_TINT:   result.red   = tint(pix.red);
            pca_pkg::MODE_CONTRAST_UP:
            begin
                result.red   = contrast(pix.red,   bright, bright);
                result.green = contrast(pix.green, bright, bright);
                result.blue  = contrast(pix.blue,  bright, bright);
            end
            pca_pkg::MODE_CONTRAST_DN:
            begin
                result.red   = contrast(pix.red,   !bright, bright);
                result.green = contrast(pix.green, !bright, bright);
                result.blue  = contrast(pix.blue,  !bright, bright);
            end
            default: result = pix;  // unused code: pass through
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/pixel_color_adjust.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_adjust
// Per-pixel RGB point operations: negative, grayscale, tints, contrast.
//
// Usage:
//   s_axis carries input pixels, m_axis carries adjusted pixels, one item
//   out for every item in. tdata holds red [7:0], green [15:8], blue [23:16].
//   cfg_valid/cfg_data write the 3-bit operation mode; cfg_ready is always
//   high. Write the mode only while no pixel is in flight.
//   An accepted item is registered in the input register, passes the
//   combinational datapath and is registered in the result register that
//   drives m_axis. Throughput is one item per cycle while the receiver
//   does not stall, set by these two register stages. When the receiver
//   stalls, the result register holds its item and the input register
//   still takes one more item; s_axis_tready drops only when both are full.
//   Reset clears both stages and sets the mode to negative.
// ----------------------------------------------------------------------------
module pixel_color_adjust (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [2:0]  cfg_data,      // op_mode
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [23:0] s_axis_tdata,  // red_in, green_in, blue_in
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [23:0] m_axis_tdata  // red_out, green_out, blue_out
);

    pca_pkg::op_mode_t mode_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    pca_pkg::pixel_t   in_pix_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    pca_pkg::pixel_t   out_pix_reg;
    pca_pkg::pixel_t   op_result;
    logic              out_load_ok;
    logic              in_accept;

    assign cfg_ready     = 1'b1;
    assign out_load_ok   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load_ok;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (out_load_ok)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        out_valid_next = out_load_ok ? in_valid_reg : out_valid_reg;
    end

    pca_pixel_op u_op (
        .mode   (mode_reg),
        .pix    (in_pix_reg),
        .result (op_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pca_pkg::MODE_NEGATIVE;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= pca_pkg::op_mode_t'(cfg_data);
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_pix_reg <= s_axis_tdata;
        if (out_load_ok && in_valid_reg)
            out_pix_reg <= op_result;
    end

endmodule
`default_nettype wire

>>> rtl/pca_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks for pixel_color_adjust, bound to the top level.
// ----------------------------------------------------------------------------
module pca_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    // input side stalls only while the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input not ready while output drains");

    // a new output item comes from an input item taken through the input and result registers
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output item without matching input item");

endmodule

bind pixel_color_adjust pca_checker u_pca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> sim/tb_pixel_color_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_color_adjust
// Self-checking bench for the pixel color adjust block. Pixels stream in
// under every operation mode, with random gaps on the input and random
// back-pressure on the output. Each accepted pixel is run through a local
// model of the point operations, and the adjusted pixels coming out are
// compared channel by channel, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_pixel_color_adjust;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red_out, green_out, blue_out

    pca_pkg::pixel_t adjusted_q[$];
    logic [2:0]      current_mode = pca_pkg::MODE_NEGATIVE;
    int              mismatch_count = 0;
    bit              source_idles = 1'b1;
    bit              sink_stalls = 1'b1;

    pixel_color_adjust DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] tint_channel(logic [7:0] c);
        int v;
        v = c + (c >> 1);
        if (v > pca_pkg::CH_MAX)
            v = pca_pkg::CH_MAX;
        return v[7:0];
    endfunction

    function automatic logic [7:0] contrast_channel(logic [7:0] c, bit raise, bit upper);
        int v;
        int lo;
        int hi;
        v  = raise ? c + (c >> 2) : c - (c >> 2);
        lo = upper ? pca_pkg::CH_MID : 0;
        hi = upper ? pca_pkg::CH_MAX : pca_pkg::CH_MID;
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        return v[7:0];
    endfunction

    function automatic pca_pkg::pixel_t adjust_pixel(pca_pkg::pixel_t p);
        pca_pkg::pixel_t q;
        int              mean;
        bit              bright;
        q      = p;
        mean   = (p.red + p.green + p.blue) / 3;
        bright = (mean > pca_pkg::CH_MID);
        case (current_mode)
            pca_pkg::MODE_NEGATIVE:
            begin
                q.red   = pca_pkg::CH_MAX - p.red;
                q.green = pca_pkg::CH_MAX - p.green;
                q.blue  = pca_pkg::CH_MAX - p.blue;
            end
            pca_pkg::MODE_GRAYSCALE:
            begin
                q.red   = mean[7:0];
                q.green = mean[7:0];
                q.blue  = mean[7:0];
            end
            pca_pkg::MODE_BLUE_TINT:  q.blue  = tint_channel(p.blue);
            pca_pkg::MODE_GREEN_TINT: q.green = tint_channel(p.green);
            pca_pkg::MODE_RED_TINT:   q.red   = tint_channel(p.red);
            pca_pkg::MODE_CONTRAST_UP:
            begin
                q.red   = contrast_channel(p.red, bright, bright);
                q.green = contrast_channel(p.green, bright, bright);
                q.blue  = contrast_channel(p.blue, bright, bright);
            end
            pca_pkg::MODE_CONTRAST_DN:
            begin
                q.red   = contrast_channel(p.red, !bright, bright);
                q.green = contrast_channel(p.green, !bright, bright);
                q.blue  = contrast_channel(p.blue, !bright, bright);
            end
            default: ;
        endcase
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure and result check
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (sink_stalls && $urandom_range(0, 99) < 30)
        begin
            m_axis_tready <= 1'b0;
            stall_left = idle_length() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pca_pkg::pixel_t got;
        pca_pkg::pixel_t want;
        string           names[3];
        names = '{"red_out", "green_out", "blue_out"};
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (adjusted_q.size() == 0)
            begin
                $display("%0t: unexpected item, none pending, got %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = adjusted_q.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got[8*i +: 8] !== want[8*i +: 8])
                    begin
                        $display("%0t: %s expected %0d, got %0d", $time, names[i],
                                 want[8*i +: 8], got[8*i +: 8]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pca_pkg::pixel_t p;
        int              gap;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        adjusted_q.push_back(adjust_pixel(p));
        gap = (source_idles && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (adjusted_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_mode(logic [2:0] mode);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        current_mode = mode;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_negative_after_reset();
        push_pixel(8'd0, 8'd255, 8'h5A);
        push_pixel(8'd255, 8'd0, 8'hA5);
    endtask

    task automatic test_grayscale();
        set_mode(pca_pkg::MODE_GRAYSCALE);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd1, 8'd1, 8'd0);
    endtask

    task automatic test_tints();
        set_mode(pca_pkg::MODE_BLUE_TINT);
        push_pixel(8'd10, 8'd20, 8'd170);
        push_pixel(8'd1, 8'd2, 8'd171);
        set_mode(pca_pkg::MODE_GREEN_TINT);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd3, 8'd170, 8'd4);
        set_mode(pca_pkg::MODE_RED_TINT);
        push_pixel(8'd171, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd1, 8'd2);
    endtask

    // mean 127 is dark, 128 bright; clamps hit from both sides
    task automatic test_contrast();
        set_mode(pca_pkg::MODE_CONTRAST_UP);
        push_pixel(8'd127, 8'd127, 8'd127);
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255);
        set_mode(pca_pkg::MODE_CONTRAST_DN);
        push_pixel(8'd128, 8'd127, 8'd127);
        push_pixel(8'd126, 8'd129, 8'd129);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_unused_mode();
        set_mode(MODE_UNUSED);
        push_pixel(8'h12, 8'h34, 8'h56);
        push_pixel(8'd255, 8'd0, 8'd255);
    endtask

    task automatic test_random_stream();
        logic [2:0] mode;
        logic [7:0] ch[3];
        int         kind;
        int         base;
        for (int phase = 0; phase < 16; phase++)
        begin
            mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            set_mode(mode);
            source_idles = ($urandom_range(0, 3) != 0);
            sink_stalls  = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 100; n++)
            begin
                kind = $urandom_range(0, 9);
                base = $urandom_range(118, 137);
                for (int i = 0; i < 3; i++)
                begin
                    if (kind < 6)
                        ch[i] = 8'($urandom);
                    else if (kind < 8)
                        ch[i] = 8'(base + $urandom_range(0, 6) - 3);
                    else
                        case ($urandom_range(0, 2))
                            0: ch[i] = 8'd0;
                            1: ch[i] = 8'd255;
                            default: ch[i] = 8'($urandom);
                        endcase
                end
                push_pixel(ch[0], ch[1], ch[2]);
                if ($urandom_range(0, 199) == 0)
                    wait_results_drained();
            end
        end
        source_idles = 1'b1;
        sink_stalls  = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_negative_after_reset();
        test_grayscale();
        test_tints();
        test_contrast();
        test_unused_mode();
        test_random_stream();
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && adjusted_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d items still pending", $time, adjusted_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
